// File: rtl/tle_pkg.sv
`timescale 1ns / 1ps
package tle_pkg;

	localparam logic [7:0] KEY_DEL    = 8'h7F;
	localparam logic [7:0] KEY_KILL   = 8'h15;
	localparam logic [7:0] KEY_WERASE = 8'h17;
	localparam logic [7:0] KEY_EOF    = 8'h04;
	localparam logic [7:0] KEY_NL     = 8'h0A;
	localparam logic [7:0] KEY_SPACE  = 8'h20;
	localparam logic [7:0] SCREEN_COLS_RESET = 8'd80;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_ECHO    = 3'd1,
		ACT_WRAP    = 3'd2,
		ACT_NEWLINE = 3'd3,
		ACT_ERASE   = 3'd4,
		ACT_BACK    = 3'd5,
		ACT_BELL    = 3'd6,
		ACT_END     = 3'd7
	} act_t;

	typedef enum logic [2:0] {
		KC_DEL,
		KC_KILL,
		KC_WERASE,
		KC_EOF,
		KC_PRINT,
		KC_NL,
		KC_OTHER
	} key_class_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_OPEN,
		DP_PUT,
		DP_ERASE1,
		DP_DROP,
		DP_KILL,
		DP_LOAD_KEEP,
		DP_LOAD_BACK,
		DP_CLRCNT,
		DP_WSTEP
	} dp_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PRINT,
		ST_NL,
		ST_WAIT,
		ST_LOAD,
		ST_WORD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic    take;
		logic    load_out;
		dp_cmd_t cmd;
		act_t    act;
	} dp_ctl_t;

	typedef struct packed {
		logic       in_valid;
		logic       out_busy;
		logic       cur_zero;
		logic       cur_full;
		logic       lines_zero;
		logic       lines_one;
		logic       char_space;
		key_class_t kclass;
	} dp_stat_t;

	function automatic key_class_t classify(input logic [7:0] b);
		key_class_t k;
		case (b) inside
			KEY_DEL:       k = KC_DEL;
			KEY_KILL:      k = KC_KILL;
			KEY_WERASE:    k = KC_WERASE;
			KEY_EOF:       k = KC_EOF;
			KEY_NL:        k = KC_NL;
			[8'h20:8'h7E]: k = KC_PRINT;
			default:       k = KC_OTHER;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/tle_if.sv
`timescale 1ns / 1ps
interface tle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface tle_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] out_char;
	logic [7:0] count;

	modport source (output valid, output action, output out_char, output count, input ready);
	modport sink (input valid, input action, input out_char, input count, output ready);
endinterface

// File: rtl/tle_ram.sv
`timescale 1ns / 1ps
module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/tle_datapath.sv
`timescale 1ns / 1ps
module tle_datapath #(
	parameter int LINE_LEN  = 40,
	parameter int MAX_LINES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	tle_in_if.sink           in_ch,
	tle_out_if.source        out_ch,
	input  tle_pkg::dp_ctl_t ctl,
	output tle_pkg::dp_stat_t stat
);
	import tle_pkg::*;

	localparam int SLOT_W = $clog2(MAX_LINES);
	localparam int SUM_W  = SLOT_W + 1;
	localparam int CNT_W  = $clog2(MAX_LINES + 1);
	localparam int CUR_W  = $clog2(LINE_LEN + 1);
	localparam int COL_W  = $clog2(LINE_LEN);
	localparam int TXT_DEPTH = MAX_LINES * (1 << COL_W);
	localparam int TXT_AW = $clog2(TXT_DEPTH);
	localparam logic [SUM_W-1:0] LINES_M = SUM_W'(MAX_LINES);
	localparam logic [CNT_W-1:0] LINES_FULL = CNT_W'(MAX_LINES);
	localparam logic [CUR_W-1:0] CUR_LIMIT = CUR_W'(LINE_LEN);

	logic [7:0]        sc_q;
	logic [7:0]        byte_q;
	logic [CUR_W-1:0]  cur_q, cur_d;
	logic [CNT_W-1:0]  lcount_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [7:0]        cnt_q;
	logic              out_valid_q;
	act_t              out_action_q;
	logic [7:0]        out_char_q, out_count_q;

	logic [SUM_W-1:0]  last_sum, next_sum;
	logic [SLOT_W-1:0] last_slot, next_slot;
	logic [CUR_W-1:0]  cur_dec, rd_col;
	logic [CUR_W-1:0]  len_rdata;
	logic [7:0]        txt_rdata;
	logic [7:0]        len_ext;
	logic              accept;

	assign accept = in_ch.valid & ctl.take;
	assign in_ch.ready = ctl.take;

	// ring slot of the last line, and the slot a newly opened line takes
	always_comb begin
		last_sum = SUM_W'(oldest_q) + SUM_W'(lcount_q) - SUM_W'(1);
		next_sum = SUM_W'(oldest_q) + SUM_W'(lcount_q);
		last_slot = (last_sum >= LINES_M) ? SLOT_W'(last_sum - LINES_M) : last_sum[SLOT_W-1:0];
		next_slot = (next_sum >= LINES_M) ? SLOT_W'(next_sum - LINES_M) : next_sum[SLOT_W-1:0];
	end

	assign cur_dec = cur_q - CUR_W'(1);

	always_comb begin
		case (ctl.cmd)
			DP_OPEN, DP_DROP, DP_KILL:     cur_d = '0;
			DP_PUT:                        cur_d = cur_q + CUR_W'(1);
			DP_ERASE1, DP_WSTEP:           cur_d = cur_dec;
			DP_LOAD_KEEP, DP_LOAD_BACK:    cur_d = len_rdata;
			default:                       cur_d = cur_q;
		endcase
	end

	// text read follows the next cursor so the character left of it is ready in the cycle after
	assign rd_col = cur_d - CUR_W'(1);

	tle_ram #(.WIDTH(8), .DEPTH(TXT_DEPTH)) u_text (
		.clk   (clk),
		.we    (ctl.cmd == DP_PUT),
		.waddr (TXT_AW'({last_slot, cur_q[COL_W-1:0]})),
		.wdata (byte_q),
		.raddr (TXT_AW'({last_slot, rd_col[COL_W-1:0]})),
		.rdata (txt_rdata)
	);

	tle_ram #(.WIDTH(CUR_W), .DEPTH(MAX_LINES)) u_len (
		.clk   (clk),
		.we    (ctl.cmd == DP_OPEN || ctl.cmd == DP_PUT || ctl.cmd == DP_ERASE1 ||
			ctl.cmd == DP_WSTEP),
		.waddr ((ctl.cmd == DP_OPEN) ? next_slot : last_slot),
		.wdata (cur_d),
		.raddr (last_slot),
		.rdata (len_rdata)
	);

	assign len_ext = 8'(len_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q        <= SCREEN_COLS_RESET;
			cur_q       <= '0;
			lcount_q    <= '0;
			oldest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sc_q <= cfg_wr_data;
			end
			cur_q <= cur_d;
			case (ctl.cmd)
				DP_OPEN: begin
					if (lcount_q == LINES_FULL) begin
						oldest_q <= (oldest_q == SLOT_W'(MAX_LINES - 1)) ? '0
							: oldest_q + SLOT_W'(1);
					end else begin
						lcount_q <= lcount_q + CNT_W'(1);
					end
				end
				DP_DROP, DP_KILL: lcount_q <= lcount_q - CNT_W'(1);
				default: ;
			endcase
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_ch.in_byte;
		end
		case (ctl.cmd)
			DP_ERASE1:    cnt_q <= 8'd1;
			DP_KILL:      cnt_q <= 8'(cur_q);
			DP_CLRCNT:    cnt_q <= '0;
			DP_WSTEP:     cnt_q <= cnt_q + 8'd1;
			DP_LOAD_BACK: cnt_q <= (sc_q > len_ext) ? sc_q - len_ext : '0;
			default: ;
		endcase
		if (ctl.load_out) begin
			out_action_q <= ctl.act;
			out_char_q   <= (ctl.act == ACT_ECHO || ctl.act == ACT_WRAP) ? byte_q : '0;
			out_count_q  <= (ctl.act == ACT_ERASE || ctl.act == ACT_BACK) ? cnt_q : '0;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.action   = out_action_q;
	assign out_ch.out_char = out_char_q;
	assign out_ch.count    = out_count_q;

	always_comb begin
		stat.in_valid   = in_ch.valid;
		stat.out_busy   = out_valid_q & ~out_ch.ready;
		stat.cur_zero   = (cur_q == '0);
		stat.cur_full   = (cur_q >= CUR_LIMIT);
		stat.lines_zero = (lcount_q == '0);
		stat.lines_one  = (lcount_q == CNT_W'(1));
		stat.char_space = (txt_rdata == KEY_SPACE);
		stat.kclass     = classify(byte_q);
	end

endmodule

// File: rtl/tle_ctrl.sv
`timescale 1ns / 1ps
module tle_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  tle_pkg::dp_stat_t stat,
	output tle_pkg::dp_ctl_t  ctl
);
	import tle_pkg::*;

	state_t state_q, state_d;
	act_t   act_q, act_d;
	logic   finished_q, finished_d;
	logic   back_q, back_d;
	logic   phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			act_q      <= ACT_NONE;
			finished_q <= 1'b0;
			back_q     <= 1'b0;
			phase_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			act_q      <= act_d;
			finished_q <= finished_d;
			back_q     <= back_d;
			phase_q    <= phase_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		act_d        = act_q;
		finished_d   = finished_q;
		back_d       = back_q;
		phase_d      = phase_q;
		ctl.take     = 1'b0;
		ctl.load_out = 1'b0;
		ctl.cmd      = DP_NOP;
		ctl.act      = act_q;

		case (state_q)
			ST_IDLE: begin
				ctl.take = 1'b1;
				if (stat.in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_FIN;
				if (finished_q) begin
					act_d = ACT_END;
				end else begin
					case (stat.kclass)
						KC_DEL: begin
							if (!stat.cur_zero) begin
								ctl.cmd = DP_ERASE1;
								act_d   = ACT_ERASE;
							end else if (stat.lines_zero) begin
								act_d = ACT_NONE;
							end else begin
								ctl.cmd = DP_DROP;
								back_d  = 1'b1;
								if (stat.lines_one) begin
									act_d = ACT_NONE;
								end else begin
									act_d   = ACT_BACK;
									state_d = ST_WAIT;
								end
							end
						end
						KC_KILL: begin
							if (stat.lines_zero) begin
								act_d = ACT_NONE;
							end else begin
								ctl.cmd = DP_KILL;
								act_d   = ACT_ERASE;
								back_d  = 1'b0;
								if (!stat.lines_one) begin
									state_d = ST_WAIT;
								end
							end
						end
						KC_WERASE: begin
							ctl.cmd = DP_CLRCNT;
							act_d   = ACT_ERASE;
							phase_d = 1'b0;
							state_d = ST_WORD;
						end
						KC_EOF: begin
							if (stat.cur_zero) begin
								finished_d = 1'b1;
								act_d      = ACT_END;
							end else begin
								act_d = ACT_NONE;
							end
						end
						KC_PRINT: begin
							act_d   = ACT_ECHO;
							state_d = ST_PRINT;
							if (stat.lines_zero) begin
								ctl.cmd = DP_OPEN;
							end
						end
						KC_NL: begin
							act_d   = ACT_NEWLINE;
							ctl.cmd = DP_OPEN;
							if (stat.lines_zero) begin
								state_d = ST_NL;
							end
						end
						default: begin
							act_d = ACT_BELL;
						end
					endcase
				end
			end
			ST_PRINT: begin
				if (stat.cur_full) begin
					ctl.cmd = DP_OPEN;
					act_d   = ACT_WRAP;
				end else begin
					ctl.cmd = DP_PUT;
					state_d = ST_FIN;
				end
			end
			ST_NL: begin
				ctl.cmd = DP_OPEN;
				state_d = ST_FIN;
			end
			// line length read address settles in the cycle after the drop
			ST_WAIT: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				ctl.cmd = back_q ? DP_LOAD_BACK : DP_LOAD_KEEP;
				state_d = ST_FIN;
			end
			// first trailing non-spaces, then the spaces before them
			ST_WORD: begin
				if (stat.cur_zero) begin
					state_d = ST_FIN;
				end else if (!phase_q) begin
					if (stat.char_space) begin
						phase_d = 1'b1;
					end else begin
						ctl.cmd = DP_WSTEP;
					end
				end else if (stat.char_space) begin
					ctl.cmd = DP_WSTEP;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!stat.out_busy) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/terminal_line_editor.sv
`timescale 1ns / 1ps
// line editor for a character terminal
// in_ch carries one keyboard byte per transaction, out_ch one echo action per
// transaction (action, out_char, count); every input byte yields exactly one result
// cfg_wr_en/cfg_wr_data set the screen width used for the cursor-back count; write
// it only while no byte is in flight
// the result register loads in ST_FIN; most bytes pass ST_DECODE and then ST_FIN,
// a printable byte or a newline with no line stored passes ST_PRINT or ST_NL in
// between, a printable byte that wraps passes ST_PRINT twice, and a delete or kill
// that drops a line and leaves lines behind passes ST_WAIT and ST_LOAD (line length
// memory read); word erase steps through the stored text in ST_WORD one character
// per cycle on the text memory read port, first over non-spaces, then over spaces
// the next byte is taken in the cycle after the result is loaded, so no new byte is
// taken while one is still being edited; this holds even while the result still
// sits in the output register; if the receiver stalls, a second finished result
// waits in the controller until the register frees up
// reset clears history, cursor and the end flag and sets screen width to 80; the
// text memory needs no clearing, only positions already typed are ever read
module terminal_line_editor #(
	parameter int LINE_LEN  = 40,
	parameter int MAX_LINES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	tle_in_if.sink     in_ch,
	tle_out_if.source  out_ch
);
	import tle_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	tle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	tle_datapath #(
		.LINE_LEN  (LINE_LEN),
		.MAX_LINES (MAX_LINES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.ctl         (ctl),
		.stat        (stat)
	);

endmodule

// File: tb/sv/terminal_line_editor_tb.sv
`timescale 1ns / 1ps
module terminal_line_editor_tb;
	import tle_pkg::*;

	localparam int LINE_LEN  = 40;
	localparam int MAX_LINES = 16;

	typedef struct packed {
		act_t       act;
		logic [7:0] ch;
		logic [7:0] cnt;
	} echo_t;

	typedef struct packed {
		logic [7:0] key;
		bit         typed;
		echo_t      want;
	} key_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	tle_in_if  in_ch ();
	tle_out_if out_ch ();

	terminal_line_editor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	// editor state mirrored from the transactions accepted so far
	logic [7:0] txt [MAX_LINES][LINE_LEN];
	logic [5:0] len [MAX_LINES];
	int         cur;
	int         nlines;
	int         oldest;
	bit         ended;
	logic [7:0] scr_cols;

	echo_t echoes_due [$];
	int    n_errors;
	int    type_run;
	int    del_run;

	// directed keys, expected echo typed in where it is obvious
	key_row_t dir_rows [25] = '{
		'{KEY_DEL,    1'b1, '{ACT_NONE,    8'h00, 8'd0}},
		'{KEY_KILL,   1'b1, '{ACT_NONE,    8'h00, 8'd0}},
		'{KEY_WERASE, 1'b1, '{ACT_ERASE,   8'h00, 8'd0}},
		'{8'h00,      1'b1, '{ACT_BELL,    8'h00, 8'd0}},
		'{8'hFF,      1'b1, '{ACT_BELL,    8'h00, 8'd0}},
		'{8'h80,      1'b1, '{ACT_BELL,    8'h00, 8'd0}},
		'{8'h1F,      1'b1, '{ACT_BELL,    8'h00, 8'd0}},
		'{KEY_SPACE,  1'b1, '{ACT_ECHO,    8'h20, 8'd0}},
		'{8'h7E,      1'b1, '{ACT_ECHO,    8'h7E, 8'd0}},
		'{KEY_SPACE,  1'b1, '{ACT_ECHO,    8'h20, 8'd0}},
		'{8'h41,      1'b1, '{ACT_ECHO,    8'h41, 8'd0}},
		'{KEY_EOF,    1'b1, '{ACT_NONE,    8'h00, 8'd0}},
		'{KEY_WERASE, 1'b0, '{ACT_NONE,    8'h00, 8'd0}},
		'{KEY_DEL,    1'b1, '{ACT_ERASE,   8'h00, 8'd1}},
		'{KEY_NL,     1'b1, '{ACT_NEWLINE, 8'h00, 8'd0}},
		'{KEY_NL,     1'b1, '{ACT_NEWLINE, 8'h00, 8'd0}},
		'{KEY_DEL,    1'b0, '{ACT_NONE,    8'h00, 8'd0}},
		'{KEY_DEL,    1'b0, '{ACT_NONE,    8'h00, 8'd0}},
		'{KEY_DEL,    1'b1, '{ACT_ERASE,   8'h00, 8'd1}},
		'{KEY_DEL,    1'b0, '{ACT_NONE,    8'h00, 8'd0}},
		'{KEY_NL,     1'b1, '{ACT_NEWLINE, 8'h00, 8'd0}},
		'{8'h55,      1'b1, '{ACT_ECHO,    8'h55, 8'd0}},
		'{KEY_KILL,   1'b0, '{ACT_NONE,    8'h00, 8'd0}},
		'{KEY_KILL,   1'b1, '{ACT_ERASE,   8'h00, 8'd0}},
		'{KEY_KILL,   1'b1, '{ACT_NONE,    8'h00, 8'd0}}
	};

	function automatic int tail_slot();
		return (oldest + nlines + MAX_LINES - 1) % MAX_LINES;
	endfunction

	function automatic void open_line();
		if (nlines >= MAX_LINES) begin
			oldest = (oldest + 1) % MAX_LINES;
			nlines = MAX_LINES;
		end else begin
			nlines++;
		end
		len[tail_slot()] = '0;
		cur = 0;
	endfunction

	function automatic void drop_line();
		nlines--;
		cur = (nlines != 0) ? int'(len[tail_slot()]) : 0;
	endfunction

	function automatic void erase_char();
		cur--;
		len[tail_slot()] = cur[5:0];
	endfunction

	function automatic echo_t echo_for(input logic [7:0] k);
		echo_t r;
		int    tail;
		int    n;
		r = '{ACT_NONE, 8'h00, 8'h00};
		n = 0;
		if (ended) begin
			r.act = ACT_END;
			return r;
		end
		case (k)
			KEY_DEL: begin
				if (cur > 0) begin
					erase_char();
					r.act = ACT_ERASE;
					r.cnt = 8'd1;
				end else if (nlines > 0) begin
					drop_line();
					if (nlines > 0) begin
						r.act = ACT_BACK;
						r.cnt = (int'(scr_cols) > cur) ? 8'(int'(scr_cols) - cur) : 8'd0;
					end
				end
			end
			KEY_KILL: begin
				if (nlines > 0) begin
					r.act = ACT_ERASE;
					r.cnt = 8'(cur);
					len[tail_slot()] = '0;
					drop_line();
				end
			end
			KEY_WERASE: begin
				tail = tail_slot();
				while (cur > 0 && txt[tail][cur-1] != KEY_SPACE) begin
					erase_char();
					n++;
				end
				while (cur > 0 && txt[tail][cur-1] == KEY_SPACE) begin
					erase_char();
					n++;
				end
				r.act = ACT_ERASE;
				r.cnt = 8'(n);
			end
			KEY_EOF: begin
				if (cur == 0) begin
					ended = 1'b1;
					r.act = ACT_END;
				end
			end
			KEY_NL: begin
				if (nlines == 0)
					open_line();
				open_line();
				r.act = ACT_NEWLINE;
			end
			default: begin
				if (k >= 8'h20 && k <= 8'h7E) begin
					r.act = ACT_ECHO;
					if (nlines == 0)
						open_line();
					if (cur >= LINE_LEN) begin
						open_line();
						r.act = ACT_WRAP;
					end
					tail = tail_slot();
					txt[tail][cur] = k;
					cur++;
					len[tail] = cur[5:0];
					r.ch = k;
				end else begin
					r.act = ACT_BELL;
				end
			end
		endcase
		return r;
	endfunction

	// words: lower-case letters with a fair share of spaces
	function automatic logic [7:0] text_char();
		if ($urandom_range(0, 3) == 0)
			return KEY_SPACE;
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	// mostly well-formed typing with edits; end of input at column 0 is held back
	function automatic logic [7:0] pick_key();
		int         r;
		logic [7:0] k;
		if (type_run > 0) begin
			type_run--;
			return text_char();
		end
		if (del_run > 0) begin
			del_run--;
			return KEY_DEL;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			type_run = $urandom_range(30, 55);
			k = text_char();
		end else if (r < 6) begin
			del_run = $urandom_range(5, 45);
			k = KEY_DEL;
		end else if (r < 52) begin
			k = text_char();
		end else if (r < 58) begin
			k = 8'($urandom_range(8'h20, 8'h7E));
		end else if (r < 68) begin
			k = KEY_NL;
		end else if (r < 76) begin
			k = KEY_DEL;
		end else if (r < 80) begin
			k = KEY_KILL;
		end else if (r < 87) begin
			k = KEY_WERASE;
		end else if (r < 91) begin
			k = (cur != 0) ? KEY_EOF : KEY_NL;
		end else begin
			k = 8'($urandom_range(0, 255));
			if (k == KEY_EOF && cur == 0)
				k = 8'h07;
		end
		return k;
	endfunction

	task automatic send_key(input logic [7:0] k, input bit typed, input echo_t want);
		echo_t e;
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.in_byte = k;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		e = echo_for(k);
		if (typed)
			e = want;
		echoes_due.insert(echoes_due.size(), e);
	endtask

	task automatic pause(input int n);
		repeat (n) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			in_ch.in_byte = 8'($urandom);
		end
	endtask

	task automatic drain();
		for (int w = 0; w < 50000 && echoes_due.size() != 0; w++)
			@(posedge clk);
		repeat (LINE_LEN + 8) @(posedge clk);
	endtask

	task automatic set_screen_cols(input logic [7:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'($urandom);
		scr_cols = v;
	endtask

	task automatic run_phase(input int n_items);
		int left;
		int burst;
		left = n_items;
		while (left > 0) begin
			burst = $urandom_range(1, 10);
			if (burst > left)
				burst = left;
			repeat (burst) send_key(pick_key(), 1'b0, '0);
			left -= burst;
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 8));
		end
		pause(1);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: runs of always ready, random ready and short full stalls
	initial begin
		int mode;
		int run;
		out_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			run = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
			repeat (run) begin
				@(negedge clk);
				case (mode)
					0: out_ch.ready = 1'b1;
					1: out_ch.ready = 1'($urandom_range(0, 1));
					2: out_ch.ready = ($urandom_range(0, 3) != 0);
					default: out_ch.ready = 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		echo_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (echoes_due.size() == 0) begin
				$display("%0t: unexpected transaction: action=%0d char=%h count=%0d",
					$time, out_ch.action, out_ch.out_char, out_ch.count);
				n_errors++;
			end else begin
				want = echoes_due.pop_front();
				if (out_ch.action !== want.act || out_ch.out_char !== want.ch
						|| out_ch.count !== want.cnt) begin
					$display("%0t: expected %0d/%h/%0d, actual %0d/%h/%0d",
						$time, want.act, want.ch, want.cnt,
						out_ch.action, out_ch.out_char, out_ch.count);
					n_errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [7:0] phase_cols [4];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'h00;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		n_errors = 0;
		type_run = 0;
		del_run = 0;
		cur = 0;
		nlines = 0;
		oldest = 0;
		ended = 1'b0;
		scr_cols = SCREEN_COLS_RESET;
		foreach (len[i])
			len[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed keys run at the reset screen width
		foreach (dir_rows[i]) begin
			send_key(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
			if ($urandom_range(0, 2) == 0)
				pause($urandom_range(1, 5));
		end
		pause(1);

		phase_cols = '{8'd255, 8'd1, 8'(LINE_LEN), 8'($urandom_range(1, 255))};
		foreach (phase_cols[p]) begin
			set_screen_cols(phase_cols[p]);
			run_phase(105);
		end

		// end of input at column 0, then everything answers end
		send_key(KEY_NL, 1'b0, '0);
		send_key(KEY_EOF, 1'b1, '{ACT_END, 8'h00, 8'd0});
		repeat (6) send_key(8'($urandom_range(0, 255)), 1'b1, '{ACT_END, 8'h00, 8'd0});
		pause(1);

		drain();
		if (echoes_due.size() != 0) begin
			$display("%0t: %0d expected transactions never arrived, next action=%0d",
				$time, echoes_due.size(), echoes_due[0].act);
			n_errors++;
		end
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
